FILE: src/sed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_pkg
// Types and constants shared by the escaped string decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

   localparam int MAX_LEN_DEF = 512;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CODE_LF      = 8'h0A;
   localparam logic [7:0] CODE_TAB     = 8'h09;
   localparam logic [7:0] CODE_BS      = 8'h08;
   localparam logic [7:0] CODE_FF      = 8'h0C;
   localparam logic [7:0] CODE_CR      = 8'h0D;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_ESC,
      MODE_OCT1,
      MODE_OCT2,
      MODE_SKIP
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_END,
      KIND_ERR
   } kind_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } result_type;

endpackage

FILE: src/string_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes backslash escapes of a NUL terminated byte string, one byte per
// request, into decoded bytes, an end marker and a too-long error.
// ----------------------------------------------------------------------------
//  channel   ports                                      direction
//  request   req_valid req_stall req_in_byte            in
//  response  rsp_valid rsp_stall rsp_out_byte           out
//            rsp_result_kind rsp_last_of_run
//
//  One request per cycle while req_stall is low; an accepted request is held
//  in the request register and decoded from there into a two-entry response
//  queue, the decode sitting between the two. A request that gives two
//  responses fills both queue entries. Reset (synchronous) empties both
//  registers and returns the decoder to normal text mode. req_stall rises when
//  the queued responses leave no room for the pending request's responses.
// ----------------------------------------------------------------------------
module string_escape_decoder
   import sed_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_result_kind,
   output logic       rsp_last_of_run
);

   localparam int CNT_W = $clog2(MAX_LEN);
   localparam logic [CNT_W:0] CNT_LIMIT = (CNT_W + 1)'(MAX_LEN - 1);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   mode_type         mode_ff, mode_in;
   logic [6:0]       accum_ff, accum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   result_type       q_ff [2];
   result_type       q_in [2];
   logic [1:0]       qcnt_ff, qcnt_in;

   logic             req_take, rsp_take, process;
   logic             is_digit;
   logic [3:0]       digit;
   logic [9:0]       oct_value;
   logic [7:0]       esc_value;
   result_type       r0, r1;
   logic [1:0]       nres;
   logic [CNT_W:0]   cnt_base;
   logic [1:0]       qfree;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   assign is_digit  = (in_byte_ff >= CH_ZERO) && (in_byte_ff <= CH_NINE);
   assign digit     = 4'(in_byte_ff - CH_ZERO);
   assign oct_value = {accum_ff, 3'b000} + {6'd0, digit};

   always_comb begin
      case (in_byte_ff)
         CH_N:    esc_value = CODE_LF;
         CH_T:    esc_value = CODE_TAB;
         CH_B:    esc_value = CODE_BS;
         CH_F:    esc_value = CODE_FF;
         CH_R:    esc_value = CODE_CR;
         default: esc_value = in_byte_ff;
      endcase
   end

   // decode of the held request against the string state
   always_comb begin
      logic run_first;
      result_type rn;
      logic nvalid;
      run_first = 1'b0;
      rn        = '{data: 8'd0, kind: KIND_BYTE, last: 1'b0};
      nvalid    = 1'b0;
      r0        = '{data: 8'd0, kind: KIND_BYTE, last: 1'b0};
      r1        = '{data: 8'd0, kind: KIND_BYTE, last: 1'b0};
      nres      = 2'd0;
      mode_in   = mode_ff;
      accum_in  = accum_ff;
      count_in  = count_ff;
      cnt_base  = {1'b0, count_ff};

      case (mode_ff)
         MODE_ESC: begin
            if (in_byte_ff == CH_NUL) begin
               mode_in  = MODE_NORMAL;
               accum_in = '0;
               count_in = '0;
               r0       = '{data: 8'd0, kind: KIND_END, last: 1'b1};
               nres     = 2'd1;
            end else if (is_digit) begin
               accum_in = {3'd0, digit};
               mode_in  = MODE_OCT1;
            end else begin
               mode_in  = MODE_NORMAL;
               count_in = count_ff + 1'b1;
               r0       = '{data: esc_value, kind: KIND_BYTE, last: 1'b1};
               nres     = 2'd1;
            end
         end
         MODE_OCT1, MODE_OCT2: begin
            if (is_digit) begin
               if (mode_ff == MODE_OCT1) begin
                  accum_in = oct_value[6:0];
                  mode_in  = MODE_OCT2;
               end else begin
                  accum_in = '0;
                  mode_in  = MODE_NORMAL;
                  count_in = count_ff + 1'b1;
                  r0       = '{data: oct_value[7:0], kind: KIND_BYTE, last: 1'b1};
                  nres     = 2'd1;
               end
            end else begin
               run_first = 1'b1;
               cnt_base  = {1'b0, count_ff} + 1'b1;
            end
         end
         MODE_SKIP: begin
            if (in_byte_ff == CH_NUL) begin
               mode_in  = MODE_NORMAL;
               accum_in = '0;
               count_in = '0;
               r0       = '{data: 8'd0, kind: KIND_END, last: 1'b1};
               nres     = 2'd1;
            end
         end
         default: begin
         end
      endcase

      if (run_first || !(mode_ff == MODE_ESC || mode_ff == MODE_OCT1 ||
                         mode_ff == MODE_OCT2 || mode_ff == MODE_SKIP)) begin
         accum_in = '0;
         mode_in  = MODE_NORMAL;
         count_in = cnt_base[CNT_W-1:0];
         if (in_byte_ff == CH_NUL) begin
            count_in = '0;
            rn       = '{data: 8'd0, kind: KIND_END, last: 1'b1};
            nvalid   = 1'b1;
         end else if (cnt_base >= CNT_LIMIT) begin
            mode_in = MODE_SKIP;
            rn      = '{data: 8'd0, kind: KIND_ERR, last: 1'b1};
            nvalid  = 1'b1;
         end else if (in_byte_ff == CH_BACKSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            count_in = CNT_W'(cnt_base + 1'b1);
            rn       = '{data: in_byte_ff, kind: KIND_BYTE, last: 1'b1};
            nvalid   = 1'b1;
         end

         if (run_first) begin
            r0   = '{data: {1'b0, accum_ff}, kind: KIND_BYTE, last: !nvalid};
            r1   = rn;
            nres = nvalid ? 2'd2 : 2'd1;
         end else begin
            r0   = rn;
            nres = {1'b0, nvalid};
         end
      end
   end

   assign qfree     = 2'd2 - qcnt_ff + {1'b0, rsp_take};
   assign process   = in_valid_ff && (nres <= qfree);
   assign req_stall = in_valid_ff && !process;

   always_comb begin
      logic [1:0] c;
      q_in = q_ff;
      c    = qcnt_ff;
      if (rsp_take) begin
         q_in[0] = q_ff[1];
         c       = c - 1'b1;
      end
      if (process && nres != 2'd0) begin
         if (c == 2'd0) begin
            q_in[0] = r0;
         end else begin
            q_in[1] = r0;
         end
         if (nres == 2'd2) begin
            q_in[1] = r1;
         end
      end
      qcnt_in = process ? c + nres : c;
   end

   assign in_valid_in = req_take ? 1'b1 : (process ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         qcnt_ff     <= 2'd0;
         mode_ff     <= MODE_NORMAL;
         accum_ff    <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         qcnt_ff     <= qcnt_in;
         if (process) begin
            mode_ff  <= mode_in;
            accum_ff <= accum_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      q_ff <= q_in;
   end

   assign rsp_valid       = qcnt_ff != 2'd0;
   assign rsp_out_byte    = q_ff[0].data;
   assign rsp_result_kind = q_ff[0].kind;
   assign rsp_last_of_run = q_ff[0].last;

endmodule
